/* src/cbbe_pkg.sv */
// Shared types and opcode constants for the extended bit and branch execute block.
`default_nettype none

package cbbe_pkg;

	// Opcodes handled one by one.
	localparam logic [7:0] OP_TSB_ZP  = 8'h04;
	localparam logic [7:0] OP_TSB_ABS = 8'h0C;
	localparam logic [7:0] OP_TRB_ZP  = 8'h14;
	localparam logic [7:0] OP_TRB_ABS = 8'h1C;
	localparam logic [7:0] OP_STZ_ZP  = 8'h64;
	localparam logic [7:0] OP_STZ_ZPX = 8'h74;
	localparam logic [7:0] OP_STZ_ABS = 8'h9C;
	localparam logic [7:0] OP_STZ_ABX = 8'h9E;
	localparam logic [7:0] OP_BRA     = 8'h80;

	// Low nibbles that select a whole column of the opcode map.
	localparam logic [3:0] LOW_SMB_RMB = 4'h7;
	localparam logic [3:0] LOW_BBS_BBR = 4'hF;

	// Base clock counts.
	localparam logic [2:0] CYC_BIT_OP  = 3'd5;
	localparam logic [2:0] CYC_TSB_ZP  = 3'd5;
	localparam logic [2:0] CYC_TSB_ABS = 3'd6;
	localparam logic [2:0] CYC_STZ_ZP  = 3'd3;
	localparam logic [2:0] CYC_STZ_ZPX = 3'd4;
	localparam logic [2:0] CYC_STZ_ABS = 3'd4;
	localparam logic [2:0] CYC_STZ_ABX = 3'd5;
	localparam logic [2:0] CYC_BRA     = 3'd2;

	typedef struct packed {
		logic [7:0]  cmd;
		logic [7:0]  operand_byte;
		logic [7:0]  accumulator;
		logic [15:0] pc_after;
		logic [7:0]  displacement;
	} item_t;

	typedef struct packed {
		logic        handled;
		logic        write_enable;
		logic [7:0]  write_value;
		logic        zero_valid;
		logic        zero_flag;
		logic        branch_taken;
		logic [15:0] next_pc;
		logic [2:0]  cycle_count;
	} result_t;

endpackage

`default_nettype wire

/* src/cbbe_exec.sv */
// Combinational execute logic: decode, bit operations, branch target and clock count.
`default_nettype none

module cbbe_exec (
	input  cbbe_pkg::item_t   item,
	output cbbe_pkg::result_t result
);

	logic [7:0]  sel_mask;
	logic        bit_set;
	logic        is_branch;
	logic        taken;
	logic [15:0] target;
	logic        page_cross;
	logic [2:0]  base_cyc;

	// Bit index comes from opcode bits 6..4.
	assign sel_mask = 8'h01 << item.cmd[6:4];
	assign bit_set  = (item.operand_byte & sel_mask) != 8'h00;
	assign target   = item.pc_after + {{8{item.displacement[7]}}, item.displacement};
	assign page_cross = target[15:8] != item.pc_after[15:8];

	always_comb begin
		result              = '0;
		result.handled      = 1'b1;
		result.next_pc      = item.pc_after;
		is_branch           = 1'b0;
		taken               = 1'b0;
		base_cyc            = 3'd0;
		if (item.cmd[3:0] == cbbe_pkg::LOW_SMB_RMB) begin
			result.write_enable = 1'b1;
			base_cyc            = cbbe_pkg::CYC_BIT_OP;
			if (item.cmd[7]) begin
				result.write_value = item.operand_byte | sel_mask;
			end else begin
				result.write_value = item.operand_byte & ~sel_mask;
			end
		end else if (item.cmd[3:0] == cbbe_pkg::LOW_BBS_BBR) begin
			// BBS tests for a set bit, BBR for a clear one.
			is_branch = 1'b1;
			base_cyc  = cbbe_pkg::CYC_BIT_OP;
			taken     = item.cmd[7] ? bit_set : ~bit_set;
		end else begin
			case (item.cmd)
				cbbe_pkg::OP_TSB_ZP, cbbe_pkg::OP_TSB_ABS: begin
					result.write_enable = 1'b1;
					result.zero_valid   = 1'b1;
					result.zero_flag    = (item.operand_byte & item.accumulator) == 8'h00;
					result.write_value  = item.operand_byte | item.accumulator;
					base_cyc = (item.cmd == cbbe_pkg::OP_TSB_ZP) ?
						cbbe_pkg::CYC_TSB_ZP : cbbe_pkg::CYC_TSB_ABS;
				end
				cbbe_pkg::OP_TRB_ZP, cbbe_pkg::OP_TRB_ABS: begin
					result.write_enable = 1'b1;
					result.zero_valid   = 1'b1;
					result.zero_flag    = (item.operand_byte & item.accumulator) == 8'h00;
					result.write_value  = item.operand_byte & ~item.accumulator;
					base_cyc = (item.cmd == cbbe_pkg::OP_TRB_ZP) ?
						cbbe_pkg::CYC_TSB_ZP : cbbe_pkg::CYC_TSB_ABS;
				end
				cbbe_pkg::OP_STZ_ZP: begin
					result.write_enable = 1'b1;
					base_cyc = cbbe_pkg::CYC_STZ_ZP;
				end
				cbbe_pkg::OP_STZ_ZPX: begin
					result.write_enable = 1'b1;
					base_cyc = cbbe_pkg::CYC_STZ_ZPX;
				end
				cbbe_pkg::OP_STZ_ABS: begin
					result.write_enable = 1'b1;
					base_cyc = cbbe_pkg::CYC_STZ_ABS;
				end
				cbbe_pkg::OP_STZ_ABX: begin
					result.write_enable = 1'b1;
					base_cyc = cbbe_pkg::CYC_STZ_ABX;
				end
				cbbe_pkg::OP_BRA: begin
					is_branch = 1'b1;
					taken     = 1'b1;
					base_cyc  = cbbe_pkg::CYC_BRA;
				end
				default: begin
					result.handled = 1'b0;
				end
			endcase
		end

		result.branch_taken = is_branch & taken;
		result.cycle_count  = base_cyc;
		if (is_branch && taken) begin
			result.next_pc = target;
			if (page_cross) begin
				result.cycle_count = base_cyc + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/cpu_bit_op_branch_execute.sv */
// Top level of the extended bit-manipulation and branch execute block.
// Usage:
//   One instruction enters per transfer on the item channel (item_valid,
//   item_stall, item) and one result leaves per transfer on the result
//   channel (result_valid, result_stall, result). Every instruction gives
//   exactly one result, also opcodes outside the group (handled = 0).
// Pipeline and throughput:
//   An instruction taken at a rising edge is captured in the input
//   register; its result is computed in one combinational pass and is
//   loaded into the result register when that register may load, which
//   raises result_valid. With no stall the block takes one instruction
//   every cycle.
// Reset:
//   arst_n low clears both stage valid bits at once; no result is offered
//   and the block is ready for a transfer as soon as reset is released.
// Stall:
//   While result_stall holds a waiting result, the input register still
//   accepts one more instruction; only when both registers are full does
//   item_stall rise. A stalled result does not change.
`default_nettype none

module cpu_bit_op_branch_execute (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  cbbe_pkg::item_t    item,
	output logic               result_valid,
	input  wire                result_stall,
	output cbbe_pkg::result_t  result
);

	// Input register stage.
	logic              valid_s1;
	cbbe_pkg::item_t   item_s1;

	// Result register stage.
	logic              valid_s2;
	cbbe_pkg::result_t result_s2;

	cbbe_pkg::result_t exec_result;
	logic              load_s2;
	logic              load_s1;

	// The result register may load when empty or when its content leaves now;
	// the input register may load when empty or when it moves forward.
	assign load_s2 = ~valid_s2 | ~result_stall;
	assign load_s1 = ~valid_s1 | load_s2;

	assign item_stall   = ~load_s1;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	cbbe_exec u_exec (
		.item   (item_s1),
		.result (exec_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= item_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			item_s1 <= item;
		end
		if (load_s2 && valid_s1) begin
			result_s2 <= exec_result;
		end
	end

	// Input back-pressure only when both stages hold an instruction.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2))
		else $error("item_stall raised with a free stage");

	// A transfer in always fills the input stage.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> valid_s1)
		else $error("accepted instruction lost from input stage");

	// An instruction in the input stage moves on when the result side is free.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(valid_s2 && result_stall)) |=> valid_s2)
		else $error("input stage did not advance");

	// Opcodes outside the group produce no side effects.
	a_unhandled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.handled) |->
			(!result.write_enable && !result.branch_taken && !result.zero_valid &&
			 result.cycle_count == 3'd0))
		else $error("unhandled opcode produced side effects");

	// No write, no write data.
	a_write_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.write_enable) |-> (result.write_value == 8'h00))
		else $error("write_value nonzero without write_enable");

endmodule

`default_nettype wire
